FILE: hdl/kruskal_quick_find_mst_unit_macros.svh
// Assertion macros for the quick-find MST unit.
// Define NO_ASSERTIONS to compile them out.
`ifndef KRUSKAL_QUICK_FIND_MST_UNIT_MACROS_SVH
`define KRUSKAL_QUICK_FIND_MST_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define KQF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("kqf assertion failed");
`define KQF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("kqf assertion failed");
`else
`define KQF_ASSERT_NOW(lbl, ante, cons)
`define KQF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/kqf_pkg.sv
package kqf_pkg;

    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 32;
    localparam int SUM_W    = 40;
    localparam int NCFG_W   = 7;

    localparam logic [SUM_W-1:0]  SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [NCFG_W-1:0] NODE_COUNT_RST = 7'd64;

    typedef enum logic [1:0] {
        TREE_BUILD = 2'd0,
        TREE_DONE  = 2'd1,
        TREE_NONE  = 2'd2
    } tree_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_MERGE
    } ctrl_state_t;

    // commands broadcast from the controller to every cell
    typedef struct packed {
        logic clear;
        logic merge;
    } cell_ctl_t;

endpackage

FILE: hdl/kruskal_quick_find_mst_unit.sv
// One edge is processed at a time; no new edge is accepted before the
// previous one has merged. The label lookup wave walks the cell chain one
// cell per cycle, then the merge state relabels, held while the previous
// result still waits.
// Reset (aresetn low, synchronous): each node in its own set, sum, count and
// status cleared, node_count = 64, no result pending.
`include "kruskal_quick_find_mst_unit_macros.svh"

module kruskal_quick_find_mst_unit
    import kqf_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NCFG_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_new_graph,
    input  logic [NODE_W-1:0]   s_node_u,
    input  logic [NODE_W-1:0]   s_node_v,
    input  logic [WEIGHT_W-1:0] s_edge_weight,
    input  logic                s_edge_present,
    input  logic                s_last_edge,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_edge_taken,
    output logic [SUM_W-1:0]    m_tree_weight,
    output logic [NODE_W-1:0]   m_tree_edges,
    output logic [1:0]          m_tree_status
);

    localparam int LW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);

    cell_ctl_t         ctl;
    logic [NODE_W-1:0] node_u, node_v;
    logic [CW-1:0]     nodes_used;
    logic [LW-1:0]     p_chain [0:MAX_NODES];
    logic [LW-1:0]     q_chain [0:MAX_NODES];

    assign p_chain[0] = '0;
    assign q_chain[0] = '0;

    kqf_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_new_graph    (s_new_graph),
        .s_node_u       (s_node_u),
        .s_node_v       (s_node_v),
        .s_edge_weight  (s_edge_weight),
        .s_edge_present (s_edge_present),
        .s_last_edge    (s_last_edge),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_edge_taken   (m_edge_taken),
        .m_tree_weight  (m_tree_weight),
        .m_tree_edges   (m_tree_edges),
        .m_tree_status  (m_tree_status),
        .seek_p         (p_chain[MAX_NODES]),
        .seek_q         (q_chain[MAX_NODES]),
        .ctl            (ctl),
        .node_u         (node_u),
        .node_v         (node_v),
        .nodes_used     (nodes_used)
    );

    // keep/drop labels are the lookup results at the end of the chain
    for (genvar i = 0; i < MAX_NODES; i++) begin : g_cell
        kqf_cell #(
            .MAX_NODES (MAX_NODES),
            .IDX       (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctl        (ctl),
            .node_u     (node_u),
            .node_v     (node_v),
            .nodes_used (nodes_used),
            .keep_label (p_chain[MAX_NODES]),
            .drop_label (q_chain[MAX_NODES]),
            .p_in       (p_chain[i]),
            .q_in       (q_chain[i]),
            .p_out      (p_chain[i+1]),
            .q_out      (q_chain[i+1])
        );
    end

    `KQF_ASSERT_NOW(a_no_clear_and_merge, 1'b1, !(ctl.clear && ctl.merge))
    `KQF_ASSERT_NOW(a_clear_on_accept, ctl.clear, s_valid && s_ready)
    `KQF_ASSERT_NEXT(a_one_item_in_flight, s_valid && s_ready, !s_ready)
    `KQF_ASSERT_NEXT(a_merge_then_result, ctl.merge, m_valid && s_ready)

endmodule

FILE: hdl/kqf_cell.sv
module kqf_cell
    import kqf_pkg::*;
#(
    parameter int MAX_NODES = 64,
    parameter int IDX       = 0,
    localparam int LW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1)
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cell_ctl_t           ctl,
    input  logic [NODE_W-1:0]   node_u,
    input  logic [NODE_W-1:0]   node_v,
    input  logic [CW-1:0]       nodes_used,
    input  logic [LW-1:0]       keep_label,
    input  logic [LW-1:0]       drop_label,
    input  logic [LW-1:0]       p_in,
    input  logic [LW-1:0]       q_in,
    output logic [LW-1:0]       p_out,
    output logic [LW-1:0]       q_out
);

    logic [LW-1:0] label_reg;
    logic [LW-1:0] p_reg;
    logic [LW-1:0] q_reg;
    logic          in_use;

    assign in_use = 32'(nodes_used) > 32'(IDX);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            label_reg <= LW'(IDX);
        end else if (ctl.clear) begin
            label_reg <= LW'(IDX);
        end else if (ctl.merge && in_use && label_reg == drop_label) begin
            label_reg <= keep_label;
        end
    end

    // lookup wave: this cell drops its label in when it is the endpoint
    always_ff @(posedge aclk) begin
        p_reg <= (32'(node_u) == 32'(IDX)) ? label_reg : p_in;
        q_reg <= (32'(node_v) == 32'(IDX)) ? label_reg : q_in;
    end

    assign p_out = p_reg;
    assign q_out = q_reg;

endmodule

FILE: hdl/kqf_ctrl.sv
module kqf_ctrl
    import kqf_pkg::*;
#(
    parameter int MAX_NODES = 64,
    localparam int LW = $clog2(MAX_NODES),
    localparam int CW = $clog2(MAX_NODES + 1),
    localparam int XW = (CW > NCFG_W) ? CW : NCFG_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NCFG_W-1:0]   cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_new_graph,
    input  logic [NODE_W-1:0]   s_node_u,
    input  logic [NODE_W-1:0]   s_node_v,
    input  logic [WEIGHT_W-1:0] s_edge_weight,
    input  logic                s_edge_present,
    input  logic                s_last_edge,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_edge_taken,
    output logic [SUM_W-1:0]    m_tree_weight,
    output logic [NODE_W-1:0]   m_tree_edges,
    output logic [1:0]          m_tree_status,
    input  logic [LW-1:0]       seek_p,
    input  logic [LW-1:0]       seek_q,
    output cell_ctl_t           ctl,
    output logic [NODE_W-1:0]   node_u,
    output logic [NODE_W-1:0]   node_v,
    output logic [CW-1:0]       nodes_used
);

    ctrl_state_t state_reg, state_next;

    logic [NCFG_W-1:0]   node_count_reg;
    logic [CW-1:0]       n_reg;
    logic [LW-1:0]       seek_cnt_reg, seek_cnt_next;
    logic [NODE_W-1:0]   u_reg, v_reg;
    logic [WEIGHT_W-1:0] w_reg;
    logic                present_reg, last_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    tree_status_t        status_reg, status_next;

    logic                m_valid_reg;
    logic                taken_out_reg;
    logic [SUM_W-1:0]    weight_out_reg;
    logic [NODE_W-1:0]   edges_out_reg;
    logic [1:0]          status_out_reg;

    logic                accept;
    logic                out_free;
    logic                do_merge;
    logic [CW-1:0]       n_eff;
    logic [XW-1:0]       nc_ext;
    tree_status_t        status0;
    logic                take;
    logic [CW-1:0]       count1;
    logic [SUM_W:0]      sum_wide;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    // node_count clamped to 1..MAX_NODES
    assign nc_ext = XW'(node_count_reg);
    always_comb begin
        priority if (node_count_reg == '0) begin
            n_eff = CW'(1);
        end else if (nc_ext > XW'(MAX_NODES)) begin
            n_eff = CW'(MAX_NODES);
        end else begin
            n_eff = CW'(nc_ext);
        end
    end

    always_comb begin
        status0 = status_reg;
        if (status_reg == TREE_BUILD
                && ({1'b0, count_reg} + (CW+1)'(1)) >= {1'b0, n_reg}) begin
            status0 = TREE_DONE;
        end
        take = (status0 == TREE_BUILD) && present_reg
            && (XW'(u_reg) < XW'(n_reg)) && (XW'(v_reg) < XW'(n_reg))
            && (seek_p != seek_q);
        count1   = count_reg + CW'(take);
        sum_wide = {1'b0, sum_reg} + (SUM_W+1)'(w_reg);
        status_next = status0;
        if (take && ({1'b0, count1} + (CW+1)'(1)) >= {1'b0, n_reg}) begin
            status_next = TREE_DONE;
        end
        if (status_next == TREE_BUILD && last_reg) begin
            status_next = TREE_NONE;
        end
        if (take) begin
            sum_next = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
        end else begin
            sum_next = sum_reg;
        end
        count_next = count1;
    end

    always_comb begin
        state_next    = state_reg;
        seek_cnt_next = seek_cnt_reg;
        do_merge      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                seek_cnt_next = '0;
                if (accept) begin
                    state_next = ST_SEEK;
                end
            end
            ST_SEEK: begin
                seek_cnt_next = seek_cnt_reg + LW'(1);
                if (seek_cnt_reg == LW'(MAX_NODES - 1)) begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE: begin
                if (out_free) begin
                    do_merge   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign ctl.clear  = accept && s_new_graph;
    assign ctl.merge  = do_merge && take;
    assign node_u     = u_reg;
    assign node_v     = v_reg;
    assign nodes_used = n_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            seek_cnt_reg   <= '0;
            node_count_reg <= NODE_COUNT_RST;
            count_reg      <= '0;
            sum_reg        <= '0;
            status_reg     <= TREE_BUILD;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg    <= state_next;
            seek_cnt_reg <= seek_cnt_next;
            if (cfg_valid && cfg_ready) begin
                node_count_reg <= cfg_data;
            end
            if (ctl.clear) begin
                count_reg  <= '0;
                sum_reg    <= '0;
                status_reg <= TREE_BUILD;
            end else if (do_merge) begin
                count_reg  <= count_next;
                sum_reg    <= sum_next;
                status_reg <= status_next;
            end
            if (do_merge) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            n_reg       <= n_eff;
            u_reg       <= s_node_u;
            v_reg       <= s_node_v;
            w_reg       <= s_edge_weight;
            present_reg <= s_edge_present;
            last_reg    <= s_last_edge;
        end
        if (do_merge) begin
            taken_out_reg  <= take;
            weight_out_reg <= sum_next;
            edges_out_reg  <= NODE_W'(count_next);
            status_out_reg <= status_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_edge_taken  = taken_out_reg;
    assign m_tree_weight = weight_out_reg;
    assign m_tree_edges  = edges_out_reg;
    assign m_tree_status = status_out_reg;

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    import kqf_pkg::*;

    localparam int MAX_NODES   = 64;
    localparam int DUT_LATENCY = MAX_NODES + 2;
    localparam int SETTLE      = DUT_LATENCY + 16;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic                new_graph;
        logic [NODE_W-1:0]   node_u;
        logic [NODE_W-1:0]   node_v;
        logic [WEIGHT_W-1:0] edge_weight;
        logic                edge_present;
        logic                last_edge;
    } edge_item_t;

    typedef struct {
        logic               taken;
        logic [SUM_W-1:0]   weight;
        logic [NODE_W-1:0]  edges;
        tree_status_t       status;
    } mst_result_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_valid      = 1'b0;
    logic                cfg_ready;
    logic [NCFG_W-1:0]   cfg_data       = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic                s_new_graph    = 1'b0;
    logic [NODE_W-1:0]   s_node_u       = '0;
    logic [NODE_W-1:0]   s_node_v       = '0;
    logic [WEIGHT_W-1:0] s_edge_weight  = '0;
    logic                s_edge_present = 1'b0;
    logic                s_last_edge    = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic                m_edge_taken;
    logic [SUM_W-1:0]    m_tree_weight;
    logic [NODE_W-1:0]   m_tree_edges;
    logic [1:0]          m_tree_status;

    kruskal_quick_find_mst_unit #(
        .MAX_NODES(MAX_NODES)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_new_graph   (s_new_graph),
        .s_node_u      (s_node_u),
        .s_node_v      (s_node_v),
        .s_edge_weight (s_edge_weight),
        .s_edge_present(s_edge_present),
        .s_last_edge   (s_last_edge),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_taken  (m_edge_taken),
        .m_tree_weight (m_tree_weight),
        .m_tree_edges  (m_tree_edges),
        .m_tree_status (m_tree_status)
    );

    // forest model
    logic [NODE_W-1:0] node_set [MAX_NODES];
    logic [NODE_W-1:0] forest_edges;
    logic [SUM_W-1:0]  forest_weight;
    tree_status_t      forest_status;
    logic [NCFG_W-1:0] node_count_cfg;

    mst_result_t mst_expected [$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int fail_count      = 0;
    int edges_sent      = 0;
    int results_checked = 0;
    int trees_done      = 0;
    int trees_none      = 0;
    int graphs_started  = 0;
    int cfg_writes      = 0;
    int cycle_count     = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void clear_forest();
        for (int i = 0; i < MAX_NODES; i++)
            node_set[i] = NODE_W'(i);
        forest_edges  = '0;
        forest_weight = '0;
        forest_status = TREE_BUILD;
    endfunction

    function automatic int active_nodes();
        if (node_count_cfg == 0)
            return 1;
        if (node_count_cfg > MAX_NODES)
            return MAX_NODES;
        return int'(node_count_cfg);
    endfunction

    function automatic void predict_edge(input edge_item_t e);
        mst_result_t       r;
        int                n;
        logic [NODE_W-1:0] keep_set;
        logic [NODE_W-1:0] drop_set;
        logic [SUM_W:0]    acc;
        n = active_nodes();
        if (e.new_graph)
            clear_forest();
        r.taken = 1'b0;
        // a single node (or a count lowered mid graph) completes before merging
        if (forest_status == TREE_BUILD && int'(forest_edges) + 1 >= n)
            forest_status = TREE_DONE;
        if (forest_status == TREE_BUILD) begin
            if (e.edge_present && int'(e.node_u) < n && int'(e.node_v) < n) begin
                keep_set = node_set[e.node_u];
                drop_set = node_set[e.node_v];
                if (keep_set != drop_set) begin
                    for (int i = 0; i < n; i++)
                        if (node_set[i] == drop_set)
                            node_set[i] = keep_set;
                    r.taken = 1'b1;
                    acc = {1'b0, forest_weight} + e.edge_weight;
                    forest_weight = (acc > SUM_MAX) ? SUM_MAX : acc[SUM_W-1:0];
                    forest_edges++;
                    if (int'(forest_edges) + 1 >= n)
                        forest_status = TREE_DONE;
                end
            end
            if (forest_status == TREE_BUILD && e.last_edge)
                forest_status = TREE_NONE;
        end
        r.weight = forest_weight;
        r.edges  = forest_edges;
        r.status = forest_status;
        mst_expected.push_back(r);
    endfunction

    function automatic edge_item_t edge_of(input logic ng, input int u, input int v,
                                           input logic [WEIGHT_W-1:0] w,
                                           input logic present, input logic last);
        edge_item_t e;
        e.new_graph    = ng;
        e.node_u       = NODE_W'(u);
        e.node_v       = NODE_W'(v);
        e.edge_weight  = w;
        e.edge_present = present;
        e.last_edge    = last;
        return e;
    endfunction

    // receiver side: random stall plus result compare
    always @(posedge aclk) begin : result_check
        mst_result_t want;
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (mst_expected.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = mst_expected.pop_front();
                results_checked++;
                if (want.taken && want.status == TREE_DONE)
                    trees_done++;
                if (want.status == TREE_NONE)
                    trees_none++;
                if (m_edge_taken !== want.taken) begin
                    $error("edge_taken: expected %0b, got %0b", want.taken, m_edge_taken);
                    fail_count++;
                end
                if (m_tree_weight !== want.weight) begin
                    $error("tree_weight: expected %h, got %h", want.weight, m_tree_weight);
                    fail_count++;
                end
                if (m_tree_edges !== want.edges) begin
                    $error("tree_edges: expected %0d, got %0d", want.edges, m_tree_edges);
                    fail_count++;
                end
                if (m_tree_status !== want.status) begin
                    $error("tree_status: expected %0d, got %0d", want.status, m_tree_status);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_edge(input edge_item_t e);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_new_graph    <= e.new_graph;
        s_node_u       <= e.node_u;
        s_node_v       <= e.node_v;
        s_edge_weight  <= e.edge_weight;
        s_edge_present <= e.edge_present;
        s_last_edge    <= e.last_edge;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_edge(e);
        edges_sent++;
        if (e.new_graph)
            graphs_started++;
    endtask

    task automatic wait_block_idle();
        s_valid <= 1'b0;
        while (mst_expected.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic apply_node_count(input logic [NCFG_W-1:0] val);
        wait_block_idle();
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        node_count_cfg = val;
        cfg_writes++;
    endtask

    // reset size 64: extremes, self loop, absent edge, last edge without a tree
    task automatic test_default_size();
        send_edge(edge_of(1'b0, 0, 63, 32'hFFFF_FFFF, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 63, 0, 32'h0000_0001, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 5, 5, 32'h0000_0002, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 1, 2, 32'h0000_0003, 1'b0, 1'b0));
        send_edge(edge_of(1'b0, 1, 2, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_edge(edge_of(1'b0, 3, 4, 32'h0000_0004, 1'b1, 1'b0));
        send_edge(edge_of(1'b1, 3, 4, 32'h0000_0000, 1'b1, 1'b0));
        send_edge(edge_of(1'b1, 6, 7, 32'h8000_0000, 1'b0, 1'b1));
    endtask

    // node count of one, and zero treated as one
    task automatic test_single_node();
        apply_node_count(7'd1);
        send_edge(edge_of(1'b1, 0, 0, 32'h0000_0010, 1'b1, 1'b0));
        apply_node_count(7'd0);
        send_edge(edge_of(1'b1, 0, 1, 32'h0000_0020, 1'b1, 1'b1));
    endtask

    // three nodes: out-of-range endpoints, completion, edges after completion
    task automatic test_small_tree();
        apply_node_count(7'd3);
        send_edge(edge_of(1'b1, 0, 1, 32'h0001_0000, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 0, 5, 32'h0001_8000, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 3, 2, 32'h0002_0000, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 2, 1, 32'h0002_8000, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 0, 2, 32'h0003_0000, 1'b1, 1'b0));
        send_edge(edge_of(1'b0, 1, 0, 32'h0004_0000, 1'b1, 1'b1));
    endtask

    // count lowered in mid graph, then a count above the node limit
    task automatic test_count_change();
        apply_node_count(7'd4);
        send_edge(edge_of(1'b1, 0, 1, 32'h0000_0100, 1'b1, 1'b0));
        apply_node_count(7'd2);
        send_edge(edge_of(1'b0, 2, 3, 32'h0000_0200, 1'b1, 1'b0));
        apply_node_count(7'd127);
        send_edge(edge_of(1'b1, 62, 63, 32'h7FFF_FFFF, 1'b1, 1'b1));
    endtask

    function automatic logic [NCFG_W-1:0] pick_node_count();
        case ($urandom_range(9))
            0:       return 7'd1;
            1:       return 7'd64;
            2:       return NCFG_W'($urandom_range(13, 63));
            3:       return ($urandom_range(1) != 0) ? 7'd0 : NCFG_W'($urandom_range(65, 127));
            default: return NCFG_W'($urandom_range(2, 12));
        endcase
    endfunction

    // sorted edge list holding a spanning tree plus extra edges, shuffled
    task automatic run_tree_graph();
        edge_item_t          list [2*MAX_NODES];
        edge_item_t          tmp;
        int                  n;
        int                  m;
        int                  j;
        int                  extra;
        logic [WEIGHT_W-1:0] w;
        n = active_nodes();
        m = 0;
        for (int i = 1; i < n; i++) begin
            list[m] = edge_of(1'b0, i, $urandom_range(i - 1), '0, 1'b1, 1'b0);
            m++;
        end
        extra = $urandom_range(1, n);
        repeat (extra) begin
            list[m] = edge_of(1'b0, $urandom_range(n - 1), $urandom_range(n - 1), '0, 1'b1, 1'b0);
            m++;
        end
        for (int i = m - 1; i > 0; i--) begin
            j = $urandom_range(i);
            tmp = list[i];
            list[i] = list[j];
            list[j] = tmp;
        end
        w = $urandom_range(0, 'hFFFF);
        for (int i = 0; i < m; i++) begin
            if ($urandom_range(1) != 0) begin
                tmp.node_u = list[i].node_v;
                list[i].node_v = list[i].node_u;
                list[i].node_u = tmp.node_u;
            end
            list[i].edge_weight  = w;
            list[i].edge_present = ($urandom_range(19) != 0);
            list[i].new_graph    = (i == 0);
            list[i].last_edge    = (i == m - 1);
            w = w + $urandom_range(0, 'h3FFFF);
            send_edge(list[i]);
        end
    endtask

    task automatic run_noise_burst();
        edge_item_t e;
        repeat ($urandom_range(3, 15)) begin
            e.new_graph    = ($urandom_range(9) == 0);
            e.node_u       = NODE_W'($urandom_range(63));
            e.node_v       = NODE_W'($urandom_range(63));
            e.edge_weight  = $urandom;
            e.edge_present = ($urandom_range(3) != 0);
            e.last_edge    = ($urandom_range(4) == 0);
            send_edge(e);
        end
    endtask

    task automatic test_random_stream(input int n_items);
        int target;
        int pick;
        target = edges_sent + n_items;
        while (edges_sent < target) begin
            pick = $urandom_range(9);
            if (pick == 0)
                apply_node_count(pick_node_count());
            else if (pick < 8)
                run_tree_graph();
            else
                run_noise_burst();
        end
    endtask

    initial begin
        clear_forest();
        node_count_cfg = NODE_COUNT_RST;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 25;
        recv_idle_pct = 52;
        test_default_size();
        test_single_node();
        test_small_tree();
        test_count_change();
        test_random_stream(240);

        send_idle_pct = 52;
        recv_idle_pct = 25;
        test_random_stream(230);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(230);

        wait_block_idle();
        $display("Sent %0d edges in %0d graphs across %0d node-count writes",
                 edges_sent, graphs_started, cfg_writes);
        $display("Checked %0d results: %0d trees completed, %0d no-tree results, %0d errors",
                 results_checked, trees_done, trees_none, fail_count);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
